### rtl/core/linear_interpolation_resampler_defines.svh
// Assertion macros shared by the resampler RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LINEAR_INTERPOLATION_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERPOLATION_RESAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define LIR_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LIR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LIR_ASSERT_NOW(label, clk_s, rst_s, ante, cons)
`define LIR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

### rtl/core/lir_pkg.sv
// Package of the linear interpolation resampler: widths, operation and status codes,
// state types and the request/response structs of the multiply-divide unit. No dependencies.
package lir_pkg;

  localparam int TIME_W = 32;
  localparam int VAL_W  = 32;
  localparam int MAG_W  = 32;
  localparam int PROD_W = 64;
  localparam int QUOT_W = 41;
  localparam int SUM_W  = 43;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);
  localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(1) << (QUOT_W - 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EXTRAP   = 2'd1;
  localparam logic [1:0] STAT_TOO_FEW  = 2'd2;
  localparam logic [1:0] STAT_ZERO_INT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_LO,
    ST_RD_HI,
    ST_SETUP,
    ST_CALC,
    ST_ARITH,
    ST_DONE
  } st_state_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV,
    AR_DONE
  } ar_state_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag_y;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_t;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } arith_rsp_t;

endpackage

### rtl/core/lir_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module lir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lir_arith.sv
// Bit-serial multiply-then-divide unit: forms |dy| * |dx| by shift-add, then divides by |dt|
// with a restoring divider, capping the quotient. Depends on lir_pkg.
module lir_arith (
  input  logic                clk,
  input  logic                rst,
  input  lir_pkg::arith_req_t req,
  output lir_pkg::arith_rsp_t rsp
);

  lir_pkg::ar_state_t state, state_next;
  logic [lir_pkg::CNT_W-1:0]  cnt;
  logic [lir_pkg::MAG_W-1:0]  my, mx_sh, dvsr, rem;
  logic [lir_pkg::PROD_W-1:0] prod;
  logic [lir_pkg::MAG_W:0]    r2, r2_diff;
  logic                       ge, over;

  assign r2      = {rem, prod[lir_pkg::PROD_W-1]};
  assign r2_diff = r2 - {1'b0, dvsr};
  assign ge      = r2 >= {1'b0, dvsr};
  assign over    = (|prod[lir_pkg::PROD_W-1:lir_pkg::QUOT_W]) ||
                   (prod[lir_pkg::QUOT_W-1] && (|prod[lir_pkg::QUOT_W-2:0]));

  always_comb begin
    state_next = state;
    unique case (state)
      lir_pkg::AR_IDLE: if (req.start) state_next = lir_pkg::AR_MUL;
      lir_pkg::AR_MUL:  if (cnt == lir_pkg::MUL_LAST) state_next = lir_pkg::AR_DIV;
      lir_pkg::AR_DIV:  if (cnt == lir_pkg::DIV_LAST) state_next = lir_pkg::AR_DONE;
      lir_pkg::AR_DONE: state_next = lir_pkg::AR_IDLE;
      default:          state_next = lir_pkg::AR_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == lir_pkg::AR_DONE);
    rsp.quot = over ? lir_pkg::QUOT_CAP : prod[lir_pkg::QUOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lir_pkg::AR_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lir_pkg::AR_IDLE: begin
        if (req.start) begin
          my    <= req.mag_y;
          mx_sh <= req.mag_x;
          dvsr  <= req.mag_t;
          prod  <= '0;
          rem   <= '0;
        end
      end
      lir_pkg::AR_MUL: begin
        prod  <= {prod[lir_pkg::PROD_W-2:0], 1'b0} +
                 (mx_sh[lir_pkg::MAG_W-1] ? {{(lir_pkg::PROD_W-lir_pkg::MAG_W){1'b0}}, my}
                                          : '0);
        mx_sh <= {mx_sh[lir_pkg::MAG_W-2:0], 1'b0};
      end
      lir_pkg::AR_DIV: begin
        rem  <= ge ? r2_diff[lir_pkg::MAG_W-1:0] : r2[lir_pkg::MAG_W-1:0];
        prod <= {prod[lir_pkg::PROD_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/linear_interpolation_resampler.sv
// Top level of the linear interpolation resampler: command decode, store scan and result stage.
// Depends on lir_pkg, lir_ram, lir_arith and linear_interpolation_resampler_defines.svh.
//
// The block holds up to DEPTH (time, value) samples in two synchronous memories. Clear and load
// beats are taken while idle; a load into a full store is dropped. A query with fewer than two
// samples goes to the result stage with the too-few status and a zero value. Any other query
// scans the time memory one entry per cycle until the first time above the query or the last
// entry, reads the two chosen samples, then runs a bit-serial unit of 32 multiply steps and 64
// divide steps; a zero interval skips the unit and answers with the lower sample's value and the
// zero-interval status. The next beat is taken once the result sits in the output register,
// which may still be waiting for the consumer.
`include "linear_interpolation_resampler_defines.svh"

module linear_interpolation_resampler #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [31:0]        time_req,
  input  logic signed [31:0] value,
  input  logic               final_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lir_pkg::st_state_t state, state_next;

  logic [CW-1:0]                count, ptr, pidx, lo_sel;
  logic                         pend, ext_first, at_end, ext_sel, end_sel;
  logic [lir_pkg::TIME_W-1:0]   q_time, t0, t1;
  logic                         q_last, neg;
  logic [AW-1:0]                lo_idx, ram_raddr;
  logic [lir_pkg::VAL_W-1:0]    v0, v1, res_value;
  logic [1:0]                   res_status;
  logic                         in_acc, out_free, ram_we, found, scan_end;
  logic [lir_pkg::TIME_W-1:0]   time_rdata;
  logic [lir_pkg::VAL_W-1:0]    val_rdata;
  logic [lir_pkg::MAG_W:0]      dt, dx, dy;
  logic                         dt_zero;
  logic [lir_pkg::SUM_W-1:0]    sum;
  logic [lir_pkg::VAL_W-1:0]    sat_value;
  lir_pkg::arith_req_t          arith_req;
  lir_pkg::arith_rsp_t          arith_rsp;

  function automatic logic [lir_pkg::MAG_W-1:0] mag(input logic [lir_pkg::MAG_W:0] d);
    logic [lir_pkg::MAG_W:0] n;
    n = -d;
    return d[lir_pkg::MAG_W] ? n[lir_pkg::MAG_W-1:0] : d[lir_pkg::MAG_W-1:0];
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  lir_ram #(.WIDTH(lir_pkg::TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (time_req),
    .raddr (ram_raddr),
    .rdata (time_rdata)
  );

  lir_ram #(.WIDTH(lir_pkg::VAL_W), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (value),
    .raddr (ram_raddr),
    .rdata (val_rdata)
  );

  lir_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (arith_req),
    .rsp (arith_rsp)
  );

  // Scan result: the first stored time above the query picks the interval.
  assign found    = pend && (time_rdata > q_time);
  assign scan_end = pend && (found || (pidx == count - CW'(1)));

  always_comb begin
    ext_sel = 1'b0;
    end_sel = 1'b0;
    if (found) begin
      if (pidx == '0) begin
        lo_sel  = '0;
        ext_sel = 1'b1;
      end else begin
        lo_sel = pidx - CW'(1);
      end
    end else begin
      lo_sel  = count - CW'(2);
      end_sel = 1'b1;
    end
  end

  assign dt      = {1'b0, t1} - {1'b0, t0};
  assign dx      = {1'b0, q_time} - {1'b0, t0};
  assign dy      = {v1[lir_pkg::VAL_W-1], v1} - {v0[lir_pkg::VAL_W-1], v0};
  assign dt_zero = (dt == '0);

  always_comb begin
    arith_req.start = (state == lir_pkg::ST_CALC) && !dt_zero;
    arith_req.mag_y = mag(dy);
    arith_req.mag_x = mag(dx);
    arith_req.mag_t = mag(dt);
  end

  always_comb begin
    if (neg) begin
      sum = {{(lir_pkg::SUM_W-lir_pkg::VAL_W){v0[lir_pkg::VAL_W-1]}}, v0} -
            {{(lir_pkg::SUM_W-lir_pkg::QUOT_W){1'b0}}, arith_rsp.quot};
    end else begin
      sum = {{(lir_pkg::SUM_W-lir_pkg::VAL_W){v0[lir_pkg::VAL_W-1]}}, v0} +
            {{(lir_pkg::SUM_W-lir_pkg::QUOT_W){1'b0}}, arith_rsp.quot};
    end
    if (sum[lir_pkg::SUM_W-1:lir_pkg::VAL_W-1] == '0 ||
        sum[lir_pkg::SUM_W-1:lir_pkg::VAL_W-1] == '1) begin
      sat_value = sum[lir_pkg::VAL_W-1:0];
    end else if (sum[lir_pkg::SUM_W-1]) begin
      sat_value = {1'b1, {(lir_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(lir_pkg::VAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lir_pkg::ST_IDLE: begin
        if (in_acc && operation == lir_pkg::OP_QUERY) begin
          state_next = (count < CW'(2)) ? lir_pkg::ST_DONE : lir_pkg::ST_SCAN;
        end
      end
      lir_pkg::ST_SCAN:  if (scan_end) state_next = lir_pkg::ST_RD_LO;
      lir_pkg::ST_RD_LO: state_next = lir_pkg::ST_RD_HI;
      lir_pkg::ST_RD_HI: state_next = lir_pkg::ST_SETUP;
      lir_pkg::ST_SETUP: state_next = lir_pkg::ST_CALC;
      lir_pkg::ST_CALC:  state_next = dt_zero ? lir_pkg::ST_DONE : lir_pkg::ST_ARITH;
      lir_pkg::ST_ARITH: if (arith_rsp.done) state_next = lir_pkg::ST_DONE;
      lir_pkg::ST_DONE:  if (out_free) state_next = lir_pkg::ST_IDLE;
      default:           state_next = lir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != lir_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      lir_pkg::ST_IDLE:  ram_we = in_acc && (operation == lir_pkg::OP_LOAD) &&
                                  (count < CW'(DEPTH));
      lir_pkg::ST_SCAN:  ram_raddr = ptr[AW-1:0];
      lir_pkg::ST_RD_LO: ram_raddr = lo_idx;
      lir_pkg::ST_RD_HI: ram_raddr = lo_idx + AW'(1);
      default:           ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lir_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && operation == lir_pkg::OP_CLEAR) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + CW'(1);
      end
      if (state == lir_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lir_pkg::ST_IDLE: begin
        ptr        <= '0;
        pend       <= 1'b0;
        q_time     <= time_req;
        q_last     <= final_req;
        res_value  <= '0;
        res_status <= lir_pkg::STAT_TOO_FEW;
      end
      lir_pkg::ST_SCAN: begin
        pend <= (ptr < count);
        pidx <= ptr;
        if (ptr < count) begin
          ptr <= ptr + CW'(1);
        end
        if (scan_end) begin
          lo_idx    <= lo_sel[AW-1:0];
          ext_first <= ext_sel;
          at_end    <= end_sel;
        end
      end
      lir_pkg::ST_RD_HI: begin
        t0 <= time_rdata;
        v0 <= val_rdata;
      end
      lir_pkg::ST_SETUP: begin
        t1 <= time_rdata;
        v1 <= val_rdata;
      end
      lir_pkg::ST_CALC: begin
        neg <= dy[lir_pkg::MAG_W] ^ dx[lir_pkg::MAG_W] ^ dt[lir_pkg::MAG_W];
        if (dt_zero) begin
          res_value  <= v0;
          res_status <= lir_pkg::STAT_ZERO_INT;
        end else if (ext_first || (at_end && q_time != t1)) begin
          res_status <= lir_pkg::STAT_EXTRAP;
        end else begin
          res_status <= lir_pkg::STAT_OK;
        end
      end
      lir_pkg::ST_ARITH: begin
        if (arith_rsp.done) begin
          res_value <= sat_value;
        end
      end
      lir_pkg::ST_DONE: begin
        if (out_free) begin
          result_value <= res_value;
          status       <= res_status;
          last         <= q_last;
        end
      end
      default: begin
      end
    endcase
  end

  `LIR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `LIR_ASSERT_NOW(a_pair_in_store, clk, rst, state == lir_pkg::ST_RD_LO,
                  CW'(lo_idx) + CW'(1) < count)
  `LIR_ASSERT_NOW(a_arith_done_expected, clk, rst, arith_rsp.done, state == lir_pkg::ST_ARITH)
  `LIR_ASSERT_NEXT(a_hold_result, clk, rst, state == lir_pkg::ST_DONE && out_valid && out_stall,
                   state == lir_pkg::ST_DONE)

endmodule
